/* rtl/altm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive log tone map package
// Shared constants, log2/exp2 tables and the fixed-point log2 helpers.
// ----------------------------------------------------------------------------
package altm_pkg;

  localparam int LOG_TAB_DEPTH = 256;
  localparam int LT_IDX_W      = $clog2(LOG_TAB_DEPTH + 1);
  localparam int LT_POS_W      = 30 + LT_IDX_W;
  localparam int EXP_STEPS     = 24;
  localparam int Q_W           = 17;
  // Input stages, exp2 chain, shift and log stages, then the divider and output.
  localparam int PIX_LATENCY   = 16 + EXP_STEPS + Q_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_AVG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS = 2'd2;

  localparam logic [31:0] AVG_RST  = 32'd65536;
  localparam logic [31:0] MAX_RST  = 32'd6553600;
  localparam logic [15:0] BIAS_RST = 16'd55706;
  localparam logic [63:0] LOG2_TEN_Q30 = 64'd3566893132;

  typedef logic [LOG_TAB_DEPTH:0][24:0] lg_tab_t;
  typedef logic [EXP_STEPS:0][31:0]     root_tab_t;

  typedef struct packed {
    logic [31:0]        avg;
    logic [31:0]        log_avg;
    logic signed [31:0] log_norm_max;
    logic [31:0]        bias_exp;
    logic [31:0]        inv_div;
  } altm_terms_t;

  // log2(1 + i/DEPTH) in Q1.24 by repeated squaring; the last entry is 1.0.
  function automatic lg_tab_t build_lg_tab();
    lg_tab_t     tab;
    logic [63:0] x;
    logic [24:0] r;
    tab = '0;
    for (int i = 0; i < LOG_TAB_DEPTH; i++) begin
      x = (64'(LOG_TAB_DEPTH + i) << 30) / 64'(LOG_TAB_DEPTH);
      r = '0;
      for (int k = 1; k <= 24; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          x = x >> 1;
          r[24-k] = 1'b1;
        end
      end
      tab[i] = r;
    end
    tab[LOG_TAB_DEPTH] = 25'd1 << 24;
    return tab;
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bt;
    n   = n_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bt > n) bt = bt >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bt != '0) begin
        if (n >= res + bt) begin
          n   = n - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-k) in Q2.30, each an integer square root of the one before.
  function automatic root_tab_t build_root_tab();
    root_tab_t   tab;
    logic [63:0] r;
    tab    = '0;
    tab[0] = 32'h8000_0000;
    for (int k = 1; k <= EXP_STEPS; k++) begin
      r      = isqrt64({32'b0, tab[k-1]} << 30);
      tab[k] = r[31:0];
    end
    return tab;
  endfunction

  localparam lg_tab_t   LG_TAB   = build_lg_tab();
  localparam root_tab_t ROOT_TAB = build_root_tab();

  function automatic logic [5:0] msb_pos(logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Fraction bits below the leading one, left aligned to 30 bits.
  function automatic logic [29:0] log_frac(logic [63:0] v, logic [5:0] e);
    logic [63:0] m;
    if (e >= 6'd30) begin
      m = v >> (e - 6'd30);
    end else begin
      m = v << (6'd30 - e);
    end
    return m[29:0];
  endfunction

  // Integer part plus interpolated table value, Q24.
  function automatic logic [31:0] log_fin(logic [5:0] e, logic [29:0] frac);
    logic [LT_POS_W-1:0] pos;
    logic [LT_IDX_W-1:0] idx;
    logic [29:0]         rem;
    logic [24:0]         lo;
    logic [24:0]         hi;
    logic [24:0]         diff;
    logic [54:0]         prod;
    pos = LT_POS_W'(frac) * LT_POS_W'(LOG_TAB_DEPTH);
    idx = pos[LT_POS_W-1:30];
    rem = pos[29:0];
    if (idx >= LT_IDX_W'(LOG_TAB_DEPTH)) idx = LT_IDX_W'(LOG_TAB_DEPTH - 1);
    lo   = LG_TAB[idx];
    hi   = LG_TAB[idx + 1'b1];
    diff = hi - lo;
    prod = {30'b0, diff} * {25'b0, rem};
    return 32'({e, 24'b0}) + 32'(lo) + 32'(prod >> 30);
  endfunction

endpackage

/* rtl/altm_pixel_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive log tone map pixel pipeline
// Fully pipelined per-pixel datapath: two log2 units, the bias power through
// a chain of exp2 root multiplies, a third log2 and a restoring divider.
// ----------------------------------------------------------------------------
module altm_pixel_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [31:0]         in_y,
  input  altm_pkg::altm_terms_t terms,
  output logic                out_valid,
  output logic [15:0]         out_l
);
  import altm_pkg::*;

  localparam logic signed [42:0] U_TWO = 43'sd33554432;   // 2.0 in Q24
  localparam logic signed [42:0] U_TOP = 43'sd402653184;  // 24.0 in Q24
  localparam logic signed [42:0] U_OFS = 43'sd536870912;  // 32.0 in Q24
  localparam logic signed [43:0] ONE_Q24 = 44'sd16777216;

  typedef struct packed {
    logic               hi_sat;
    logic               lo_zero;
    logic signed [42:0] u;
    logic [5:0]         n;
    logic [23:0]        f;
    logic [31:0]        mant;
    logic [63:0]        num;
  } exp_t;

  typedef struct packed {
    logic               hi_sat;
    logic               lo_zero;
    logic signed [42:0] u;
    logic [63:0]        num;
  } tail_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] rem;
    logic [47:0] den;
    logic [Q_W-1:0] q;
  } div_t;

  logic [PIX_LATENCY-1:0] vld_r;
  logic [PIX_LATENCY-2:0] zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIX_LATENCY-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= {zero_r[PIX_LATENCY-3:0], (in_y == '0)};
  end

  // Stages 1 to 4: log2 of Y and of Y + avg.
  logic [32:0] p1_y_r, p1_s_r, p2_y_r, p2_s_r;
  logic [5:0]  p2_ey_r, p2_es_r, p3_ey_r, p3_es_r;
  logic [29:0] p3_fy_r, p3_fs_r;
  logic [31:0] p4_ly_r, p4_ls_r;

  always_ff @(posedge clk) begin
    p1_y_r  <= {1'b0, in_y};
    p1_s_r  <= {1'b0, in_y} + {1'b0, terms.avg};
    p2_y_r  <= p1_y_r;
    p2_s_r  <= p1_s_r;
    p2_ey_r <= msb_pos({31'b0, p1_y_r});
    p2_es_r <= msb_pos({31'b0, p1_s_r});
    p3_ey_r <= p2_ey_r;
    p3_es_r <= p2_es_r;
    p3_fy_r <= log_frac({31'b0, p2_y_r}, p2_ey_r);
    p3_fs_r <= log_frac({31'b0, p2_s_r}, p2_es_r);
    p4_ly_r <= log_fin(p3_ey_r, p3_fy_r);
    p4_ls_r <= log_fin(p3_es_r, p3_fs_r);
  end

  // From stage 5: numerator, exponent of the normalized ratio, then 2 + t.
  logic [31:0]        p5_n2_r;
  logic signed [33:0] p5_d_r;
  logic               p6_neg_r, p7_neg_r;
  logic [32:0]        p6_abs_r;
  logic [63:0]        p6_num_r, p7_num_r, p8_num_r;
  logic [65:0]        p7_prod;
  logic [40:0]        p7_mag_r;
  logic signed [42:0] p8_u_r;
  logic signed [42:0] p9_v;
  logic signed [33:0] p5_d_sub;

  assign p5_d_sub = $signed({2'b0, p4_ly_r}) - $signed({2'b0, terms.log_avg})
                    - $signed({{2{terms.log_norm_max[31]}}, terms.log_norm_max});
  assign p7_prod  = {34'b0, terms.bias_exp} * {33'b0, p6_abs_r};
  assign p9_v     = p8_u_r + U_OFS;

  always_ff @(posedge clk) begin
    p5_n2_r  <= p4_ls_r - terms.log_avg;
    p5_d_r   <= p5_d_sub;
    p6_neg_r <= p5_d_r[33];
    p6_abs_r <= p5_d_r[33] ? 33'(-p5_d_r) : p5_d_r[32:0];
    p6_num_r <= {32'b0, p5_n2_r} * {32'b0, terms.inv_div};
    p7_neg_r <= p6_neg_r;
    p7_num_r <= p6_num_r;
    p7_mag_r <= p7_prod[64:24];
    p8_num_r <= p7_num_r;
    p8_u_r   <= (p7_neg_r ? -$signed({2'b0, p7_mag_r}) : $signed({2'b0, p7_mag_r}))
                + U_TWO;
  end

  // Stage 9 and the exp2 chain: one root multiply per stage.
  exp_t ex_r [0:EXP_STEPS];

  always_ff @(posedge clk) begin
    ex_r[0].hi_sat  <= (p8_u_r >= U_TOP);
    ex_r[0].lo_zero <= (p8_u_r < -U_OFS);
    ex_r[0].u       <= p8_u_r;
    ex_r[0].n       <= p9_v[29:24];
    ex_r[0].f       <= p9_v[23:0];
    ex_r[0].mant    <= 32'h4000_0000;
    ex_r[0].num     <= p8_num_r;
  end

  for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_exp
    logic [63:0] prod;
    exp_t        ex_nxt;
    assign prod = {32'b0, ex_r[k-1].mant} * {32'b0, ROOT_TAB[k]};
    always_comb begin
      ex_nxt = ex_r[k-1];
      if (ex_r[k-1].f[EXP_STEPS-k]) begin
        ex_nxt.mant = prod[61:30];
      end
    end
    always_ff @(posedge clk) begin
      ex_r[k] <= ex_nxt;
    end
  end

  // Scale 2^frac by the integer part, add one and take log2 again.
  exp_t        ex_last;
  logic [63:0] sh_e;
  logic [63:0] sh_x_r, lm_x_r;
  logic [5:0]  lm_e_r, lf_e_r;
  logic [29:0] lf_frac_r;
  logic [31:0] lx_r;
  tail_t       tl_r [0:3];

  assign ex_last = ex_r[EXP_STEPS];

  always_comb begin
    if (ex_last.n >= 6'd30) begin
      sh_e = {32'b0, ex_last.mant} << (ex_last.n - 6'd30);
    end else begin
      sh_e = {32'b0, ex_last.mant} >> (6'd30 - ex_last.n);
    end
  end

  always_ff @(posedge clk) begin
    sh_x_r    <= sh_e + (64'd1 << 32);
    tl_r[0]   <= '{hi_sat: ex_last.hi_sat, lo_zero: ex_last.lo_zero,
                   u: ex_last.u, num: ex_last.num};
    tl_r[1]   <= tl_r[0];
    tl_r[2]   <= tl_r[1];
    tl_r[3]   <= tl_r[2];
    lm_x_r    <= sh_x_r;
    lm_e_r    <= msb_pos(sh_x_r);
    lf_e_r    <= lm_e_r;
    lf_frac_r <= log_frac(lm_x_r, lm_e_r);
    lx_r      <= log_fin(lf_e_r, lf_frac_r);
  end

  // Denominator term W2 = 1 + log2(1 + 2^u).
  logic signed [43:0] w_soft;
  logic signed [43:0] w_sum;
  logic [39:0]        w_w2_r;
  logic [63:0]        w_num_r;

  always_comb begin
    if (tl_r[3].hi_sat) begin
      w_soft = {tl_r[3].u[42], tl_r[3].u};
    end else if (tl_r[3].lo_zero) begin
      w_soft = '0;
    end else begin
      w_soft = $signed({12'b0, lx_r}) - $signed({U_OFS[42], U_OFS});
    end
    w_sum = w_soft + ONE_Q24;
  end

  always_ff @(posedge clk) begin
    w_w2_r  <= w_sum[39:0];
    w_num_r <= tl_r[3].num;
  end

  // Rounded quotient, one restoring step per stage.
  logic [47:0] n_den;
  logic [63:0] n_sum;
  div_t        dv_r [0:Q_W];

  assign n_den = {w_w2_r, 8'b0};
  assign n_sum = w_num_r + {17'b0, w_w2_r, 7'b0};

  always_ff @(posedge clk) begin
    dv_r[0].sat <= (n_sum >= ({16'b0, n_den} << Q_W));
    dv_r[0].rem <= n_sum;
    dv_r[0].den <= n_den;
    dv_r[0].q   <= '0;
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_div
    logic [63:0] trial;
    div_t        dv_nxt;
    assign trial = {16'b0, dv_r[j-1].den} << (Q_W - j);
    always_comb begin
      dv_nxt = dv_r[j-1];
      if (dv_r[j-1].rem >= trial) begin
        dv_nxt.rem      = dv_r[j-1].rem - trial;
        dv_nxt.q[Q_W-j] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      dv_r[j] <= dv_nxt;
    end
  end

  logic [15:0] out_l_r;

  always_ff @(posedge clk) begin
    if (zero_r[PIX_LATENCY-2]) begin
      out_l_r <= '0;
    end else if (dv_r[Q_W].sat || dv_r[Q_W].q[Q_W-1]) begin
      out_l_r <= 16'hFFFF;
    end else begin
      out_l_r <= dv_r[Q_W].q[15:0];
    end
  end

  assign out_valid = vld_r[PIX_LATENCY-1];
  assign out_l     = out_l_r;

endmodule

/* rtl/adaptive_log_tone_map_pixel_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive log tone map pixel unit
// Throughput: one word per clock while busy is low; the pipeline has no
// stall path. After reset and after each register write, busy stays high
// while the log terms are rebuilt by a small sequencer and a 32-step
// divider. Reset is synchronous and loads the default registers.
// ----------------------------------------------------------------------------
module adaptive_log_tone_map_pixel_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [31:0]                    in_world_luminance,
  output logic                           out_strobe,
  output logic [15:0]                    out_display_luminance,
  input  logic                           cfg_we,
  input  logic [altm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import altm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MSB  = 3'd1;
  localparam logic [2:0] ST_NORM = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_PREP = 3'd4;
  localparam logic [2:0] ST_DSET = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;

  localparam logic [1:0] OP_AVG  = 2'd0;
  localparam logic [1:0] OP_MAX  = 2'd1;
  localparam logic [1:0] OP_SUM  = 2'd2;
  localparam logic [1:0] OP_BIAS = 2'd3;

  logic [31:0] avg_r, max_r;
  logic [15:0] bias_r;
  logic [2:0]  state_r;
  logic [1:0]  op_r;
  logic [5:0]  ce_r;
  logic [29:0] cf_r;
  logic [31:0] clog_r [4];
  logic signed [32:0] cd2_r;
  logic [63:0] crem_r;
  logic [4:0]  ccnt_r;
  logic [31:0] cq_r;

  logic [31:0]        log_avg_r;
  logic signed [31:0] log_nmax_r;
  logic [31:0]        bias_exp_r;
  logic [31:0]        inv_div_r;

  logic [31:0] avg1, max1;
  logic [15:0] bias1;
  logic [63:0] opv;
  logic [63:0] c_trial;
  logic [63:0] c_num;
  logic [31:0] cq_nxt;
  logic        cfg_hit;

  assign avg1  = (avg_r == '0) ? 32'd1 : avg_r;
  assign max1  = (max_r == '0) ? 32'd1 : max_r;
  assign bias1 = (bias_r == '0) ? 16'd1 : bias_r;
  assign cfg_hit = cfg_we && (cfg_index <= REG_BIAS);

  always_comb begin
    case (op_r)
      OP_AVG:  opv = {32'b0, avg1};
      OP_MAX:  opv = {32'b0, max1};
      OP_SUM:  opv = {32'b0, max1} + {32'b0, avg1};
      OP_BIAS: opv = {48'b0, bias1};
      default: opv = '0;
    endcase
  end

  assign c_trial = {32'b0, cd2_r[31:0]} << ccnt_r;
  assign c_num   = (LOG2_TEN_Q30 << 18) + {33'b0, cd2_r[31:1]};

  always_comb begin
    cq_nxt = cq_r;
    if (crem_r >= c_trial) cq_nxt[ccnt_r] = 1'b1;
  end

  // Register file and the sequencer that rebuilds the derived terms.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r   <= AVG_RST;
      max_r   <= MAX_RST;
      bias_r  <= BIAS_RST;
      state_r <= ST_MSB;
      op_r    <= OP_AVG;
    end else if (cfg_hit) begin
      case (cfg_index)
        REG_AVG: avg_r  <= cfg_wdata;
        REG_MAX: max_r  <= cfg_wdata;
        default: bias_r <= cfg_wdata[15:0];
      endcase
      state_r <= ST_MSB;
      op_r    <= OP_AVG;
    end else begin
      case (state_r)
        ST_MSB:  state_r <= ST_NORM;
        ST_NORM: state_r <= ST_FIN;
        ST_FIN: begin
          op_r    <= op_r + 2'd1;
          state_r <= (op_r == OP_BIAS) ? ST_PREP : ST_MSB;
        end
        ST_PREP: state_r <= ST_DSET;
        ST_DSET: begin
          if (cd2_r <= 0 || c_num >= ({32'b0, cd2_r[31:0]} << 32)) begin
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ccnt_r == '0) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_MSB:  ce_r <= msb_pos(opv);
      ST_NORM: cf_r <= log_frac(opv, ce_r);
      ST_FIN:  clog_r[op_r] <= log_fin(ce_r, cf_r);
      ST_PREP: begin
        log_avg_r  <= clog_r[OP_AVG];
        log_nmax_r <= $signed(clog_r[OP_MAX] - clog_r[OP_AVG]);
        bias_exp_r <= (32'd16 << 24) - clog_r[OP_BIAS];
        cd2_r      <= $signed({1'b0, clog_r[OP_SUM]}) - $signed({1'b0, clog_r[OP_AVG]});
      end
      ST_DSET: begin
        crem_r <= c_num;
        ccnt_r <= 5'd31;
        cq_r   <= '0;
        // A vanishing divider or an oversized quotient pins the reciprocal.
        if (cd2_r <= 0 || c_num >= ({32'b0, cd2_r[31:0]} << 32)) begin
          inv_div_r <= 32'hFFFF_FFFF;
        end
      end
      ST_DIV: begin
        if (crem_r >= c_trial) crem_r <= crem_r - c_trial;
        cq_r   <= cq_nxt;
        ccnt_r <= ccnt_r - 5'd1;
        if (ccnt_r == '0) inv_div_r <= cq_nxt;
      end
      default: ;
    endcase
  end

  altm_terms_t terms;

  assign terms = '{avg: avg1, log_avg: log_avg_r, log_norm_max: log_nmax_r,
                   bias_exp: bias_exp_r, inv_div: inv_div_r};
  assign busy  = (state_r != ST_IDLE);

  altm_pixel_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_y      (in_world_luminance),
    .terms     (terms),
    .out_valid (out_strobe),
    .out_l     (out_display_luminance)
  );

endmodule

/* rtl/altm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive log tone map port checker
// Port-level checks on reset, register writes and pixel latency.
// ----------------------------------------------------------------------------
module altm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [31:0]                    in_world_luminance,
  input logic                           out_strobe,
  input logic [15:0]                    out_display_luminance,
  input logic                           cfg_we,
  input logic [altm_pkg::CFG_IDX_W-1:0] cfg_index
);
  import altm_pkg::*;

  // The derived terms are always rebuilt after reset.
  a_rst_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index <= REG_BIAS |=> busy)
    else $error("register write did not start a rebuild");

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe right after reset");

  // A black pixel maps to zero after the full pipeline delay.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_world_luminance == '0
    |-> ##PIX_LATENCY (out_strobe && out_display_luminance == '0))
    else $error("zero word not mapped to zero on time");

endmodule

bind adaptive_log_tone_map_pixel_unit altm_checker u_altm_checker (.*);

/* tb/sv/adaptive_log_tone_map_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive log tone map checker
// Follows the register writes and the accepted pixel words, predicts each
// display luminance in fixed point and compares it with the strobed result.
// ----------------------------------------------------------------------------
module adaptive_log_tone_map_pixel_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [31:0]                    in_world_luminance,
  input  logic                           out_strobe,
  input  logic [15:0]                    out_display_luminance,
  input  logic                           cfg_we,
  input  logic [altm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  output int                             mismatches,
  output int                             pending
);
  import altm_pkg::*;

  localparam int     TAB_DEPTH = 256;
  localparam longint UNIT      = longint'(1) << 24;
  localparam longint MANT_ONE  = longint'(1) << 30;

  longint      log_curve[0:TAB_DEPTH];
  longint      half_roots[0:24];
  logic [15:0] luma_queue[$];

  logic [31:0] avg_reg;
  logic [31:0] max_reg;
  logic [15:0] bias_reg;
  longint      norm_max_log;
  longint      bias_pow;
  longint      inv_scale;

  function automatic longint int_sqrt(longint n_in);
    longint n, res, bt;
    n   = n_in;
    res = 0;
    bt  = longint'(1) << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n   = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Base-2 logarithm of a nonzero integer, 24 fraction bits.
  function automatic longint fix_log2(longint v);
    int     e;
    longint m, frac, pos, idx, rem, lo, hi;
    if (v == 0) return 0;
    e = 0;
    while ((v >> e) > 1) e++;
    m    = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
    frac = m - MANT_ONE;
    pos  = frac * TAB_DEPTH;
    idx  = pos >> 30;
    rem  = pos & (MANT_ONE - 1);
    if (idx >= TAB_DEPTH) idx = TAB_DEPTH - 1;
    lo = log_curve[idx];
    hi = log_curve[idx + 1];
    return (longint'(e) << 24) + lo + (((hi - lo) * rem) >> 30);
  endfunction

  function automatic longint fix_exp2_frac(longint f);
    longint mant;
    mant = MANT_ONE;
    for (int k = 1; k <= 24; k++) begin
      if ((f >> (24 - k)) & 1) mant = (mant * half_roots[k]) >> 30;
    end
    return mant;
  endfunction

  // log2(1 + 2^u), both with 24 fraction bits.
  function automatic longint soft_plus_log(longint u);
    longint v, n, mant, e;
    if (u >= 24 * UNIT) return u;
    if (u < -32 * UNIT) return 0;
    v    = u + 32 * UNIT;
    n    = v >> 24;
    mant = fix_exp2_frac(v & 64'hFF_FFFF);
    e    = (n >= 30) ? (mant << (n - 30)) : (mant >> (30 - n));
    return fix_log2(e + (longint'(1) << 32)) - 32 * UNIT;
  endfunction

  function automatic longint at_least_one(longint r);
    return (r == 0) ? 1 : r;
  endfunction

  function automatic void rebuild_terms();
    longint avg, mx, a, d2, q;
    avg = at_least_one(avg_reg);
    mx  = at_least_one(max_reg);
    a   = fix_log2(avg);
    d2  = fix_log2(mx + avg) - a;
    norm_max_log = fix_log2(mx) - a;
    bias_pow     = 16 * UNIT - fix_log2(at_least_one(bias_reg));
    if (d2 <= 0) begin
      inv_scale = 64'hFFFF_FFFF;
    end else begin
      q = ((longint'(LOG2_TEN_Q30) << 18) + d2 / 2) / d2;
      inv_scale = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
    end
  endfunction

  function automatic logic [15:0] map_luminance(logic [31:0] y_in);
    longint y, avg, a, n2, d, mag, t, w2, num, den, l;
    y = y_in;
    if (y == 0) return '0;
    avg = at_least_one(avg_reg);
    a   = fix_log2(avg);
    n2  = fix_log2(y + avg) - a;
    d   = fix_log2(y) - a - norm_max_log;
    mag = (bias_pow * ((d < 0) ? -d : d)) >> 24;
    t   = (d < 0) ? -mag : mag;
    w2  = UNIT + soft_plus_log(t + 2 * UNIT);
    num = n2 * inv_scale;
    den = w2 << 8;
    l   = (num + den / 2) / den;
    return (l > 64'hFFFF) ? 16'hFFFF : l[15:0];
  endfunction

  initial begin
    longint x, r;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      x = (longint'(TAB_DEPTH + i) << 30) / TAB_DEPTH;
      r = 0;
      for (int k = 1; k <= 24; k++) begin
        x = (x * x) >> 30;
        if (x >= (longint'(2) << 30)) begin
          x = x >> 1;
          r = r | (longint'(1) << (24 - k));
        end
      end
      log_curve[i] = r;
    end
    log_curve[TAB_DEPTH] = UNIT;
    half_roots[0] = longint'(1) << 31;
    for (int k = 1; k <= 24; k++) half_roots[k] = int_sqrt(half_roots[k-1] << 30);
    mismatches = 0;
  end

  assign pending = luma_queue.size();

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst_n) begin
      avg_reg  = AVG_RST;
      max_reg  = MAX_RST;
      bias_reg = BIAS_RST;
      rebuild_terms();
      luma_queue.delete();
    end else begin
      if (out_strobe) begin
        if (luma_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("luma check: unexpected word %h", out_display_luminance);
        end else begin
          want = luma_queue.pop_front();
          if (want !== out_display_luminance) begin
            mismatches++;
            if (mismatches <= 10)
              $display("luma check: expected %h got %h", want, out_display_luminance);
          end
        end
      end
      if (start && !busy) luma_queue.push_back(map_luminance(in_world_luminance));
      // Writes to an unused index leave the registers alone.
      if (cfg_we) begin
        case (cfg_index)
          REG_AVG: begin
            avg_reg = cfg_wdata;
            rebuild_terms();
          end
          REG_MAX: begin
            max_reg = cfg_wdata;
            rebuild_terms();
          end
          REG_BIAS: begin
            bias_reg = cfg_wdata[15:0];
            rebuild_terms();
          end
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/sv/adaptive_log_tone_map_pixel_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive log tone map pixel unit testbench
// Streams pixel words in random bursts through several register settings,
// extremes included; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module adaptive_log_tone_map_pixel_unit_tb;
  import altm_pkg::*;

  localparam int     CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [31:0]          in_world_luminance = '0;
  logic                 out_strobe;
  logic [15:0]          out_display_luminance;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_AVG;
  logic [31:0]          cfg_wdata = '0;
  int                   mismatches;
  int                   pending;
  int                   cycles = 0;
  int                   burst_left = 0;

  always #6 clk = ~clk;

  adaptive_log_tone_map_pixel_unit dut (.*);

  adaptive_log_tone_map_pixel_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Presents one word and holds it until the unit takes it.
  task automatic send_pixel(logic [31:0] word);
    logic taken;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    start              <= 1'b1;
    in_world_luminance <= word;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    burst_left--;
  endtask

  task automatic drain();
    if (start) start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_registers(logic [31:0] avg, logic [31:0] mx, logic [15:0] bias_val);
    drain();
    repeat (PIX_LATENCY + 8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_AVG;
    cfg_wdata <= avg;
    @(posedge clk);
    cfg_index <= REG_MAX;
    cfg_wdata <= mx;
    @(posedge clk);
    // Upper data bits must not leak into the 16-bit bias register.
    cfg_index <= REG_BIAS;
    cfg_wdata <= {16'($urandom), bias_val};
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_pixel();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom;
    if (pick < 8) return $urandom >> $urandom_range(0, 31);
    if (pick < 9) return $urandom_range(0, 3);
    return ~($urandom >> $urandom_range(20, 31));
  endfunction

  initial begin
    logic [31:0] directed[$];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0064_0000,
                 32'h0064_0001, 32'h0000_8000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000,
                 32'h00C8_0000, 32'h0002_0000, 32'h0000_0002, 32'h1000_0000};
    foreach (directed[i]) send_pixel(directed[i]);

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: ;
        1: set_registers(32'h0, 32'h0, 16'h0);
        2: set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        3: set_registers(32'h1, 32'hFFFF_FFFF, 16'h1);
        4: set_registers(32'hFFFF_FFFF, 32'h1, 16'h8000);
        5: set_registers(32'h0001_0000, 32'h03E8_0000, BIAS_RST);
        default: set_registers($urandom >> $urandom_range(0, 24),
                               $urandom >> $urandom_range(0, 16),
                               16'($urandom));
      endcase
      if (phase == 1 || phase == 2) send_pixel(32'h0);
      for (int n = 0; n < 190; n++) begin
        if (n == 95 && phase == 5) drain();
        send_pixel(random_pixel());
      end
    end

    drain();
    repeat (PIX_LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
